FILE: rtl/core/boxavg_pkg.sv
// Shared constants, register codes and payload types for the box-average downscaler.
// No dependencies; the top level and boxavg_divider use it.
package boxavg_pkg;

    localparam int PIX_W       = 8;
    localparam int COORD_W     = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int BLOCK_CFG_W = 5;
    localparam int PIX_MAX     = 255;

    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_COLUMNS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_ROWS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE     = 2'd2;

    localparam int RST_SOURCE_COLUMNS = 640;
    localparam int RST_SOURCE_ROWS    = 480;
    localparam int RST_BLOCK_SIZE     = 2;

    typedef struct packed {
        logic [PIX_W-1:0] src_red;
        logic [PIX_W-1:0] src_green;
        logic [PIX_W-1:0] src_blue;
    } t_src;

    typedef struct packed {
        logic [PIX_W-1:0]   avg_red;
        logic [PIX_W-1:0]   avg_green;
        logic [PIX_W-1:0]   avg_blue;
        logic [COORD_W-1:0] out_column;
        logic [COORD_W-1:0] out_row;
        logic               frame_done;
    } t_avg;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  wr_data;
    } t_cfg;

endpackage

FILE: rtl/core/boxavg_stream_if.sv
// Valid/ready channel carrying one item of a payload type.
// Payload types come from boxavg_pkg.
interface boxavg_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/box_average_image_downscale_unit.sv
// Top level of the box-average image downscaler: position tracking, row store
// read-modify-write sequencing and output register. Uses boxavg_pkg,
// boxavg_stream_if, boxavg_row_store and boxavg_divider.
//
//  port   | dir | payload                                   | accepted when
//  i_cfg  | in  | reg_index, wr_data                        | valid & ready
//  i_src  | in  | src_red, src_green, src_blue              | valid & ready
//  o_avg  | out | avg_red/green/blue, out_column, out_row,  | valid & ready
//         |     | frame_done                                |
//
// A pixel inside a block row span is taken while the sequencer stays idle; the pixel that closes a block
// row span also needs a row store read, then add and write back on the one port.
// The pixel that closes a block goes through write back, 8 divider steps (one
// quotient bit per cycle), the divider done flag and the output register load.
// Reset is synchronous; the row store is not cleared and no clearing pass runs.
// A stalled output holds the next block result in the divider until the register frees.
module box_average_image_downscale_unit #(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ROWS    = 4096,
    parameter int MAX_BLOCK   = 16
) (
    input logic             i_clk,
    input logic             i_rst_n,
    boxavg_stream_if.sink   i_cfg,
    boxavg_stream_if.sink   i_src,
    boxavg_stream_if.source o_avg
);

    localparam int PIXMAX = boxavg_pkg::PIX_MAX;
    localparam int OCW    = boxavg_pkg::COORD_W;
    localparam int CW     = $clog2(MAX_COLUMNS);
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int PW     = $clog2(MAX_BLOCK);
    localparam int CLW    = $clog2(MAX_COLUMNS + 1);
    localparam int RLW    = $clog2(MAX_ROWS + 1);
    localparam int BW     = $clog2(MAX_BLOCK + 1);
    localparam int AW     = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
    localparam int HW     = $clog2(MAX_BLOCK * PIXMAX + 1);
    localparam int SW     = $clog2(MAX_BLOCK * MAX_BLOCK * PIXMAX + 1);
    localparam int XW     = $clog2(MAX_COLUMNS + MAX_BLOCK + 1);
    localparam int YW     = $clog2(MAX_ROWS + MAX_BLOCK + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RMW  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    function automatic int clamp_val(int v, int hi);
        int res;
        res = v;
        if (v < 1) begin
            res = 1;
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

    // configuration, stored already clamped
    logic [CLW-1:0] r_cols;
    logic [RLW-1:0] r_rows;
    logic [BW-1:0]  r_blk;
    logic [AW-1:0]  r_area;

    // frame position
    logic [CW-1:0] r_col,  n_col;
    logic [RW-1:0] r_row,  n_row;
    logic [PW-1:0] r_cph,  n_cph;
    logic [PW-1:0] r_rph,  n_rph;
    logic [CW-1:0] r_ocol, n_ocol;
    logic [RW-1:0] r_orow, n_orow;
    logic [2:0][HW-1:0] r_hsum, n_hsum;

    // item in flight
    logic [1:0]         r_state, n_state;
    logic               r_emit;
    logic               r_first;
    logic               r_fd;
    logic [CW-1:0]      r_oc;
    logic [RW-1:0]      r_or;
    logic [2:0][HW-1:0] r_hs;

    boxavg_pkg::t_avg r_out;
    logic             r_out_valid;

    logic                          src_acc, cfg_acc, cfg_hit;
    logic [2:0][boxavg_pkg::PIX_W-1:0] px;
    logic                          col_whole, row_whole, whole;
    logic                          col_end, row_end, col_wrap, row_wrap;
    logic                          fd_col, fd_row;
    logic                          mem_rd, mem_wr;
    logic [CW-1:0]                 mem_addr;
    logic [2:0][SW-1:0]            mem_rdata, n_sum;
    logic                          div_done;
    logic [2:0][boxavg_pkg::PIX_W-1:0] quot;
    logic                          out_load;

    assign i_cfg.ready = 1'b1;
    assign i_src.ready = (r_state == ST_IDLE);
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign src_acc     = i_src.valid && i_src.ready;
    assign cfg_hit     = cfg_acc && (i_cfg.data.reg_index inside
                         {boxavg_pkg::REG_SOURCE_COLUMNS, boxavg_pkg::REG_SOURCE_ROWS,
                          boxavg_pkg::REG_BLOCK_SIZE});

    assign px[0] = i_src.data.src_red;
    assign px[1] = i_src.data.src_green;
    assign px[2] = i_src.data.src_blue;

    // phase equals position modulo block size, so the block is whole when its
    // last column (row) lies inside the frame
    assign col_whole = (XW'(r_col) + XW'(r_blk) - XW'(1) - XW'(r_cph)) < XW'(r_cols);
    assign row_whole = (YW'(r_row) + YW'(r_blk) - YW'(1) - YW'(r_rph)) < YW'(r_rows);
    assign whole     = col_whole && row_whole;
    assign col_end   = BW'(r_cph) >= (r_blk - BW'(1));
    assign row_end   = BW'(r_rph) >= (r_blk - BW'(1));
    assign col_wrap  = (CLW'(r_col) + CLW'(1)) >= r_cols;
    assign row_wrap  = (RLW'(r_row) + RLW'(1)) >= r_rows;
    assign fd_col    = (XW'(r_col) + XW'(r_blk)) >= XW'(r_cols);
    assign fd_row    = (YW'(r_row) + YW'(r_blk)) >= YW'(r_rows);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_cph == '0) begin
                n_hsum[k] = HW'(px[k]);
            end else begin
                n_hsum[k] = r_hsum[k] + HW'(px[k]);
            end
        end
    end

    always_comb begin
        n_col  = r_col + CW'(1);
        n_cph  = col_end ? '0 : r_cph + PW'(1);
        n_ocol = col_end ? r_ocol + CW'(1) : r_ocol;
        n_row  = r_row;
        n_rph  = r_rph;
        n_orow = r_orow;
        if (col_wrap) begin
            n_col  = '0;
            n_cph  = '0;
            n_ocol = '0;
            if (row_wrap) begin
                n_row  = '0;
                n_rph  = '0;
                n_orow = '0;
            end else begin
                n_row  = r_row + RW'(1);
                n_rph  = row_end ? '0 : r_rph + PW'(1);
                n_orow = row_end ? r_orow + RW'(1) : r_orow;
            end
        end
    end

    assign mem_rd   = src_acc && whole && col_end && (r_rph != '0);
    assign mem_wr   = (r_state == ST_RMW);
    assign mem_addr = mem_wr ? r_oc : r_ocol;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_first) begin
                n_sum[k] = SW'(r_hs[k]);
            end else begin
                n_sum[k] = mem_rdata[k] + SW'(r_hs[k]);
            end
        end
    end

    boxavg_row_store #(
        .DEPTH (MAX_COLUMNS),
        .WIDTH (3 * SW)
    ) u_store (
        .i_clk   (i_clk),
        .i_wr_en (mem_wr),
        .i_rd_en (mem_rd),
        .i_addr  (mem_addr),
        .i_wdata (n_sum),
        .o_rdata (mem_rdata)
    );

    boxavg_divider #(
        .SUM_W  (SW),
        .AREA_W (AW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mem_wr && r_emit),
        .i_dividend (n_sum),
        .i_divisor  (r_area),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    assign out_load = (r_state == ST_OUT) && (!r_out_valid || o_avg.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (src_acc && whole && col_end) begin
                    n_state = ST_RMW;
                end
            end
            ST_RMW: begin
                n_state = r_emit ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols      <= CLW'(clamp_val(boxavg_pkg::RST_SOURCE_COLUMNS, MAX_COLUMNS));
            r_rows      <= RLW'(clamp_val(boxavg_pkg::RST_SOURCE_ROWS, MAX_ROWS));
            r_blk       <= BW'(clamp_val(boxavg_pkg::RST_BLOCK_SIZE, MAX_BLOCK));
            r_col       <= '0;
            r_row       <= '0;
            r_cph       <= '0;
            r_rph       <= '0;
            r_ocol      <= '0;
            r_orow      <= '0;
            r_hsum      <= '0;
            r_state     <= ST_IDLE;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_acc) begin
                case (i_cfg.data.reg_index)
                    boxavg_pkg::REG_SOURCE_COLUMNS: begin
                        r_cols <= CLW'(clamp_val(int'(i_cfg.data.wr_data), MAX_COLUMNS));
                    end
                    boxavg_pkg::REG_SOURCE_ROWS: begin
                        r_rows <= RLW'(clamp_val(int'(i_cfg.data.wr_data), MAX_ROWS));
                    end
                    boxavg_pkg::REG_BLOCK_SIZE: begin
                        r_blk <= BW'(clamp_val(
                            int'(i_cfg.data.wr_data[boxavg_pkg::BLOCK_CFG_W-1:0]), MAX_BLOCK));
                    end
                    default: begin
                    end
                endcase
            end
            if (cfg_hit) begin
                r_col  <= '0;
                r_row  <= '0;
                r_cph  <= '0;
                r_rph  <= '0;
                r_ocol <= '0;
                r_orow <= '0;
                r_hsum <= '0;
            end else if (src_acc) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_cph  <= n_cph;
                r_rph  <= n_rph;
                r_ocol <= n_ocol;
                r_orow <= n_orow;
                if (whole) begin
                    r_hsum <= n_hsum;
                end
            end
            if (src_acc && whole && col_end) begin
                r_emit <= row_end;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_avg.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_area <= AW'(r_blk) * AW'(r_blk);
        if (src_acc && whole && col_end) begin
            r_first <= (r_rph == '0);
            r_fd    <= fd_col && fd_row;
            r_oc    <= r_ocol;
            r_or    <= r_orow;
            r_hs    <= n_hsum;
        end
        if (out_load) begin
            r_out.avg_red    <= quot[0];
            r_out.avg_green  <= quot[1];
            r_out.avg_blue   <= quot[2];
            r_out.out_column <= OCW'(r_oc);
            r_out.out_row    <= OCW'(r_or);
            r_out.frame_done <= r_fd;
        end
    end

    assign o_avg.valid = r_out_valid;
    assign o_avg.data  = r_out;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    a_col_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        BW'(r_cph) < r_blk)
        else $error("column phase reached block size");

    a_row_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        BW'(r_rph) < r_blk)
        else $error("row phase reached block size");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CLW'(r_col) < r_cols)
        else $error("source column beyond row length");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("output valid raised without a finished block");

endmodule

FILE: rtl/core/boxavg_row_store.sv
// Row store of per-output-column block sums: one port, synchronous write and read.
// Read data is registered. No dependencies.
module boxavg_row_store #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_rd_en) begin
            o_rdata <= mem[i_addr];
        end
    end

endmodule

FILE: rtl/core/boxavg_divider.sv
// Three-lane restoring divider, one quotient bit per cycle, 8-bit quotients.
// Dividend is known to be below 256 times the divisor. Uses boxavg_pkg.
module boxavg_divider #(
    parameter int SUM_W  = 16,
    parameter int AREA_W = 9
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [2:0][SUM_W-1:0]                  i_dividend,
    input  logic [AREA_W-1:0]                      i_divisor,
    output logic                                   o_done,
    output logic [2:0][boxavg_pkg::PIX_W-1:0]      o_quot
);

    localparam int QW   = boxavg_pkg::PIX_W;
    localparam int REMW = AREA_W + QW;
    localparam int BITW = $clog2(QW);

    logic [2:0][REMW-1:0] r_rem;
    logic [2:0][QW-1:0]   r_quot;
    logic [AREA_W-1:0]    r_div;
    logic [BITW-1:0]      r_bit;
    logic                 r_busy;
    logic                 r_done;
    logic [REMW-1:0]      shifted;

    assign shifted = REMW'(r_div) << r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_bit == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_bit  <= BITW'(QW - 1);
            end else if (r_busy) begin
                r_bit <= r_bit - BITW'(1);
                if (r_bit == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            for (int k = 0; k < 3; k++) begin
                r_rem[k]  <= REMW'(i_dividend[k]);
                r_quot[k] <= '0;
            end
        end else if (r_busy) begin
            for (int k = 0; k < 3; k++) begin
                if (r_rem[k] >= shifted) begin
                    r_rem[k]         <= r_rem[k] - shifted;
                    r_quot[k][r_bit] <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
